FILE: src/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// nrmc_pkg
// Status codes, character constants, capture tables and digit decoding for
// the RMC sentence parser.
// ----------------------------------------------------------------------------
`default_nettype none

package nrmc_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOT_RMC  = 3'd1,
        ST_NO_STAR  = 3'd2,
        ST_BAD_SUM  = 3'd3,
        ST_MISSING  = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    typedef logic [3:0] digit_t;
    typedef logic [2:0] cap_off_t;

    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_STAR   = 8'h2A;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;

    localparam int PREFIX_LEN   = 7;
    localparam int NUM_FIELDS   = 9;
    localparam int NUM_CAPTURES = 5;
    localparam int NUM_DIGITS   = 15;
    localparam int FIX_CAPTURE  = 1;

    localparam cap_off_t CAP_IDLE = 3'd7;

    // per capture: field it starts in, characters taken, first digit slot
    localparam logic [3:0] CAP_FIELD [NUM_CAPTURES] = '{4'd0, 4'd1, 4'd2, 4'd4, 4'd8};
    localparam cap_off_t   CAP_LEN   [NUM_CAPTURES] = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd6};
    localparam logic [3:0] CAP_BASE  [NUM_CAPTURES] = '{4'd0, 4'd0, 4'd4, 4'd6, 4'd9};

    typedef struct packed {
        logic [7:0]  day;
        logic [7:0]  month;
        logic [7:0]  year;
        logic [10:0] longitude_degrees;
        logic [7:0]  latitude_degrees;
        logic [7:0]  fix_status;
        logic [7:0]  minute;
        logic [7:0]  hour;
        status_t     status_code;
    } result_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        begin
            unique case (idx)
                3'd0:    c = 8'h24; // $
                3'd1:    c = 8'h47; // G
                3'd2:    c = 8'h50; // P
                3'd3:    c = 8'h52; // R
                3'd4:    c = 8'h4D; // M
                3'd5:    c = 8'h43; // C
                3'd6:    c = 8'h2C; // ,
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // hex digit value; anything that is not a hex digit reads as zero
    function automatic digit_t digit_value(input logic [7:0] c);
        digit_t d;
        begin
            if (c >= 8'h30 && c <= 8'h39)
                d = c[3:0];
            else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
                d = 4'(c[3:0] + 4'd9);
            else
                d = 4'd0;
            return d;
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/nmea_rmc_sentence_parser_unit.sv
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser_unit
// Parses RMC sentences from a byte stream and emits one status result with
// time, fix, position degrees and date for every finished sentence.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                  | accepted when
//  --------+-----+------------------------------------------+-------------------
//  s_*     | in  | one received byte                        | s_tvalid & s_tready
//  m_*     | out | status and decoded fields, one/sentence  | m_tvalid & m_tready
//
//  One byte per cycle unless a stalled result holds it. A byte is held in the input register, then the parser
//  state and the result are updated in a single pass into the result register.
//  Reset returns to hunting for a start character with all state cleared.
//  A stalled result holds only bytes that would produce another result;
//  bytes that yield no result keep flowing.
//
`default_nettype none

module nmea_rmc_sentence_parser_unit
    import nrmc_pkg::*;
#(
    parameter int MAX_SENTENCE_BYTES = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [2:0] status_code, [10:3] hour, [18:11] minute, [26:19] fix_status,
    // [34:27] latitude_degrees, [45:35] longitude_degrees, [53:46] year,
    // [61:54] month, [69:62] day, [71:70] zero
    output logic [71:0]      m_tdata
);

    localparam int CW = $clog2(MAX_SENTENCE_BYTES + 1);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // parser state
    logic          in_sentence_reg, in_sentence_next;
    logic [CW-1:0] byte_count_reg,  byte_count_next;
    logic          prev_cr_reg,     prev_cr_next;
    logic          prefix_ok_reg,   prefix_ok_next;
    logic [7:0]    xor_reg,         xor_next;
    logic          star_seen_reg,   star_seen_next;
    logic [1:0]    after_star_reg,  after_star_next;
    digit_t        check_reg [2];
    digit_t        check_next [2];
    logic [3:0]    field_num_reg,   field_num_next;
    logic          field_err_reg,   field_err_next;
    logic          has_chars_reg,   has_chars_next;
    cap_off_t      cap_off_reg [NUM_CAPTURES];
    cap_off_t      cap_off_next [NUM_CAPTURES];
    digit_t        digits_reg [NUM_DIGITS];
    digit_t        digits_next [NUM_DIGITS];
    logic [7:0]    fix_char_reg,    fix_char_next;

    // result register
    logic    out_valid_reg;
    result_t out_data_reg;

    logic    emit;
    result_t result;
    logic    advance;
    logic    out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!emit || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

    always_comb
    begin
        logic [7:0]    b;
        logic [CW-1:0] p;
        digit_t        dv;
        logic          do_clear;
        logic [3:0]    fn_inc;
        logic [7:0]    rx_sum;
        cap_off_t      off;

        b        = in_byte_reg;
        p        = byte_count_reg;
        dv       = digit_value(b);
        do_clear = 1'b0;
        emit     = 1'b0;
        result   = '0;
        fn_inc   = 4'(field_num_reg + 4'd1);
        rx_sum   = 8'h00;
        off      = CAP_IDLE;

        in_sentence_next = in_sentence_reg;
        byte_count_next  = byte_count_reg;
        prev_cr_next     = prev_cr_reg;
        prefix_ok_next   = prefix_ok_reg;
        xor_next         = xor_reg;
        star_seen_next   = star_seen_reg;
        after_star_next  = after_star_reg;
        check_next       = check_reg;
        field_num_next   = field_num_reg;
        field_err_next   = field_err_reg;
        has_chars_next   = has_chars_reg;
        cap_off_next     = cap_off_reg;
        digits_next      = digits_reg;
        fix_char_next    = fix_char_reg;

        if (!in_sentence_reg) begin
            // state is already clear while hunting
            if (b == CHR_DOLLAR) begin
                in_sentence_next = 1'b1;
                byte_count_next  = CW'(1);
            end
        end else if (p >= CW'(MAX_SENTENCE_BYTES)) begin
            emit               = 1'b1;
            result.status_code = ST_OVERFLOW;
            do_clear           = 1'b1;
        end else begin
            if (p < CW'(PREFIX_LEN) && b != prefix_char(p[2:0]))
                prefix_ok_next = 1'b0;

            if (b == CHR_STAR) begin
                star_seen_next  = 1'b1;
                after_star_next = 2'd0;
            end else if (!star_seen_reg) begin
                xor_next = xor_reg ^ b;
            end else if (after_star_reg < 2'd2) begin
                check_next[after_star_reg[0]] = dv;
                after_star_next = 2'(after_star_reg + 2'd1);
            end

            if (p >= CW'(PREFIX_LEN)) begin
                // arm the time field on the first byte after the prefix
                if (p == CW'(PREFIX_LEN)) begin
                    for (int c = 0; c < NUM_CAPTURES; c++)
                        if (CAP_FIELD[c] == 4'd0)
                            cap_off_next[c] = 3'd0;
                end
                for (int c = 0; c < NUM_CAPTURES; c++) begin
                    off = cap_off_next[c];
                    if (off < CAP_LEN[c]) begin
                        if (c == FIX_CAPTURE)
                            fix_char_next = b;
                        else
                            digits_next[4'(CAP_BASE[c] + 4'(off))] = dv;
                        cap_off_next[c] = (3'(off + 3'd1) >= CAP_LEN[c]) ? CAP_IDLE
                                                                         : 3'(off + 3'd1);
                    end
                end
                if (field_num_reg < 4'(NUM_FIELDS)) begin
                    if (b == CHR_COMMA) begin
                        if (!has_chars_reg)
                            field_err_next = 1'b1;
                        field_num_next = fn_inc;
                        has_chars_next = 1'b0;
                        if (fn_inc < 4'(NUM_FIELDS)) begin
                            for (int c = 0; c < NUM_CAPTURES; c++)
                                if (CAP_FIELD[c] == fn_inc)
                                    cap_off_next[c] = 3'd0;
                        end
                    end else begin
                        has_chars_next = 1'b1;
                    end
                end
            end

            if (prev_cr_reg && b == CHR_LF) begin
                emit     = 1'b1;
                do_clear = 1'b1;
                rx_sum   = {check_next[0], check_next[1]};
                if (!prefix_ok_next)
                    result.status_code = ST_NOT_RMC;
                else if (!star_seen_next)
                    result.status_code = ST_NO_STAR;
                else if (xor_next != rx_sum)
                    result.status_code = ST_BAD_SUM;
                else if (field_num_next < 4'(NUM_FIELDS) || field_err_next)
                    result.status_code = ST_MISSING;
                else begin
                    result.status_code       = ST_OK;
                    result.hour              = 8'(digits_next[0]) * 8'd10 + 8'(digits_next[1]);
                    result.minute            = 8'(digits_next[2]) * 8'd10 + 8'(digits_next[3]);
                    result.fix_status        = fix_char_next;
                    result.latitude_degrees  = 8'(digits_next[4]) * 8'd10 + 8'(digits_next[5]);
                    result.longitude_degrees = 11'(digits_next[6]) * 11'd100
                                             + 11'(digits_next[7]) * 11'd10
                                             + 11'(digits_next[8]);
                    result.year              = 8'(digits_next[13]) * 8'd10 + 8'(digits_next[14]);
                    result.month             = 8'(digits_next[11]) * 8'd10 + 8'(digits_next[12]);
                    result.day               = 8'(digits_next[9]) * 8'd10 + 8'(digits_next[10]);
                end
            end else begin
                prev_cr_next    = (b == CHR_CR);
                byte_count_next = CW'(p + CW'(1));
            end
        end

        // drop back to hunting with everything cleared
        if (do_clear) begin
            in_sentence_next = 1'b0;
            byte_count_next  = '0;
            prev_cr_next     = 1'b0;
            prefix_ok_next   = 1'b1;
            xor_next         = 8'h00;
            star_seen_next   = 1'b0;
            after_star_next  = 2'd0;
            check_next       = '{default: 4'd0};
            field_num_next   = 4'd0;
            field_err_next   = 1'b0;
            has_chars_next   = 1'b0;
            cap_off_next     = '{default: CAP_IDLE};
            digits_next      = '{default: 4'd0};
            fix_char_next    = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_sentence_reg <= 1'b0;
            byte_count_reg  <= '0;
            prev_cr_reg     <= 1'b0;
            prefix_ok_reg   <= 1'b1;
            xor_reg         <= 8'h00;
            star_seen_reg   <= 1'b0;
            after_star_reg  <= 2'd0;
            check_reg       <= '{default: 4'd0};
            field_num_reg   <= 4'd0;
            field_err_reg   <= 1'b0;
            has_chars_reg   <= 1'b0;
            cap_off_reg     <= '{default: CAP_IDLE};
            digits_reg      <= '{default: 4'd0};
            fix_char_reg    <= 8'h00;
        end else if (advance) begin
            in_sentence_reg <= in_sentence_next;
            byte_count_reg  <= byte_count_next;
            prev_cr_reg     <= prev_cr_next;
            prefix_ok_reg   <= prefix_ok_next;
            xor_reg         <= xor_next;
            star_seen_reg   <= star_seen_next;
            after_star_reg  <= after_star_next;
            check_reg       <= check_next;
            field_num_reg   <= field_num_next;
            field_err_reg   <= field_err_next;
            has_chars_reg   <= has_chars_next;
            cap_off_reg     <= cap_off_next;
            digits_reg      <= digits_next;
            fix_char_reg    <= fix_char_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            out_data_reg <= result;
    end

endmodule

`default_nettype wire

FILE: test/nmea_rmc_sentence_parser_unit_test.sv
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser_unit_test
// Streams RMC sentences, broken sentences and line noise into the parser one
// byte per request. A byte-level model of the parser predicts every status
// report. Each report is checked field by field as it leaves the block. Both
// stream sides pause and stall at random.
// ----------------------------------------------------------------------------

module nmea_rmc_sentence_parser_unit_test
    import nrmc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_MAX    = 128;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;

    // field capture: field it starts in, characters taken, first digit slot
    localparam int TAKE_FIELD [5] = '{0, 1, 2, 4, 8};
    localparam int TAKE_LEN   [5] = '{4, 1, 2, 3, 6};
    localparam int TAKE_SLOT  [5] = '{0, 0, 4, 6, 9};
    localparam int TAKE_IDLE  = 7;
    localparam int FIX_TAKE   = 1;

    localparam logic [7:0] RMC_HEAD [7] = '{"$", "G", "P", "R", "M", "C", ","};
    // typical field widths for generated sentences
    localparam int FIELD_WIDTH [9] = '{6, 1, 9, 1, 10, 1, 4, 5, 6};

    typedef enum int {SUM_UPPER, SUM_LOWER, SUM_WRONG, SUM_NONE} sum_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    // parser shadow state
    logic       in_frame;
    int         frame_pos;
    logic       last_was_cr;
    logic       header_ok;
    logic [7:0] xor_acc;
    logic       star_seen;
    int         sum_chars;
    logic [3:0] sum_digit [2];
    int         field_idx;
    logic       empty_field;
    logic       field_nonempty;
    int         take_pos [5];
    logic [3:0] digits [15];
    logic [7:0] fix_char;

    result_t    expected_reports [$];
    logic [7:0] frame_buf [$];

    int  reports_due = 0;
    int  bytes_sent = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  tx_gaps_on = 1'b0;
    bit  rx_stall_on = 1'b0;

    nmea_rmc_sentence_parser_unit #(
        .MAX_SENTENCE_BYTES(FRAME_MAX)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // parser prediction
    // ------------------------------------------------------------------
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 4'(c - 8'h30);
        if (c >= "A" && c <= "F")
            return 4'(c - 8'h37);
        if (c >= "a" && c <= "f")
            return 4'(c - 8'h57);
        return 4'd0;
    endfunction

    function automatic int pair_value(input int i);
        return digits[i] * 10 + digits[i + 1];
    endfunction

    task automatic clear_parser();
        in_frame       = 1'b0;
        frame_pos      = 0;
        last_was_cr    = 1'b0;
        header_ok      = 1'b1;
        xor_acc        = 8'd0;
        star_seen      = 1'b0;
        sum_chars      = 0;
        sum_digit[0]   = 4'd0;
        sum_digit[1]   = 4'd0;
        field_idx      = 0;
        empty_field    = 1'b0;
        field_nonempty = 1'b0;
        fix_char       = 8'd0;
        foreach (take_pos[c])
            take_pos[c] = TAKE_IDLE;
        foreach (digits[i])
            digits[i] = 4'd0;
    endtask

    task automatic arm_field(input int f);
        for (int c = 0; c < 5; c++)
            if (TAKE_FIELD[c] == f)
                take_pos[c] = 0;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        result_t    r;
        int         pos;
        logic [7:0] rx_sum;
        if (!in_frame) begin
            if (b == CHR_DOLLAR) begin
                clear_parser();
                in_frame  = 1'b1;
                frame_pos = 1;
            end
            return;
        end

        pos = frame_pos;
        if (pos >= FRAME_MAX) begin
            // drop the byte and report the runaway sentence
            r = '0;
            r.status_code = ST_OVERFLOW;
            expected_reports.push_back(r);
            reports_due++;
            clear_parser();
            return;
        end

        if (pos < PREFIX_LEN && b != RMC_HEAD[pos])
            header_ok = 1'b0;

        if (b == CHR_STAR) begin
            star_seen = 1'b1;
            sum_chars = 0;
        end
        else if (!star_seen) begin
            xor_acc ^= b;
        end
        else if (sum_chars < 2) begin
            sum_digit[sum_chars] = hex_value(b);
            sum_chars++;
        end

        if (pos >= PREFIX_LEN) begin
            if (pos == PREFIX_LEN)
                arm_field(0);
            for (int c = 0; c < 5; c++) begin
                if (take_pos[c] < TAKE_LEN[c]) begin
                    if (c == FIX_TAKE)
                        fix_char = b;
                    else
                        digits[(TAKE_SLOT[c] + take_pos[c]) % 15] = hex_value(b);
                    take_pos[c] = (take_pos[c] + 1 >= TAKE_LEN[c]) ? TAKE_IDLE
                                                                  : take_pos[c] + 1;
                end
            end
            if (field_idx < NUM_FIELDS) begin
                if (b == CHR_COMMA) begin
                    if (!field_nonempty)
                        empty_field = 1'b1;
                    field_idx++;
                    field_nonempty = 1'b0;
                    if (field_idx < NUM_FIELDS)
                        arm_field(field_idx);
                end
                else begin
                    field_nonempty = 1'b1;
                end
            end
        end

        if (last_was_cr && b == CHR_LF) begin
            rx_sum = {sum_digit[0], sum_digit[1]};
            r = '0;
            if (!header_ok)
                r.status_code = ST_NOT_RMC;
            else if (!star_seen)
                r.status_code = ST_NO_STAR;
            else if (xor_acc != rx_sum)
                r.status_code = ST_BAD_SUM;
            else if (field_idx < NUM_FIELDS || empty_field)
                r.status_code = ST_MISSING;
            else begin
                r.status_code       = ST_OK;
                r.hour              = 8'(pair_value(0));
                r.minute            = 8'(pair_value(2));
                r.fix_status        = fix_char;
                r.latitude_degrees  = 8'(pair_value(4));
                r.longitude_degrees = 11'(digits[6] * 100 + pair_value(7));
                r.year              = 8'(pair_value(13));
                r.month             = 8'(pair_value(11));
                r.day               = 8'(pair_value(9));
            end
            expected_reports.push_back(r);
            reports_due++;
            clear_parser();
            return;
        end

        last_was_cr = (b == CHR_CR);
        frame_pos   = pos + 1;
    endtask

    // ------------------------------------------------------------------
    // stimulus plumbing
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int roll;
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        // hold the request until the parser takes it
        do
            @(posedge clk);
        while (!s_tready);
        parse_rx_byte(b);
        bytes_sent++;
        gap = 0;
        if (tx_gaps_on) begin
            roll = $urandom_range(0, 99);
            if (roll >= 92)
                gap = $urandom_range(6, 20);
            else if (roll >= 55)
                gap = $urandom_range(1, 3);
        end
        repeat (gap) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return (lower ? 8'h57 : 8'h37) + 8'(v);
    endfunction

    function automatic logic [7:0] body_sum();
        logic [7:0] s;
        s = 8'd0;
        foreach (frame_buf[i]) begin
            if (frame_buf[i] == CHR_STAR)
                break;
            s ^= frame_buf[i];
        end
        return s;
    endfunction

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            frame_buf.push_back(s[i]);
    endtask

    task automatic ship_raw();
        foreach (frame_buf[i])
            send_byte(frame_buf[i]);
        frame_buf.delete();
    endtask

    // wrap the body in '$' ... '*hh' CR LF and send it
    task automatic ship_frame(input sum_mode_t mode);
        logic [7:0] s;
        s = body_sum();
        if (mode == SUM_WRONG)
            s ^= 8'(1 << $urandom_range(0, 7));
        frame_buf.push_front(CHR_DOLLAR);
        if (mode != SUM_NONE) begin
            frame_buf.push_back(CHR_STAR);
            frame_buf.push_back(hex_char(s[7:4], mode == SUM_LOWER));
            frame_buf.push_back(hex_char(s[3:0], mode == SUM_LOWER));
        end
        frame_buf.push_back(CHR_CR);
        frame_buf.push_back(CHR_LF);
        ship_raw();
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_field_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return 8'h30 + 8'($urandom_range(0, 9));
        if (roll < 90)
            return hex_char(4'($urandom_range(10, 15)), 1'($urandom_range(0, 1)));
        if (roll < 95)
            return ".";
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : ready_gen
        int roll;
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (!rx_stall_on) begin
            m_tready <= 1'b1;
        end
        else begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                m_tready <= 1'b1;
            end
            else if (roll < 93) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(10, 40);
            end
        end
    end

    task automatic check_field(input string name, input logic [10:0] got,
                               input logic [10:0] want);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : report_check
        result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                $error("report with none pending: %h", m_tdata);
                error_count++;
            end
            else begin
                want = expected_reports.pop_front();
                check_field("status_code", 11'(m_tdata[2:0]), 11'(want.status_code));
                check_field("hour", 11'(m_tdata[10:3]), 11'(want.hour));
                check_field("minute", 11'(m_tdata[18:11]), 11'(want.minute));
                check_field("fix_status", 11'(m_tdata[26:19]), 11'(want.fix_status));
                check_field("latitude_degrees", 11'(m_tdata[34:27]),
                            11'(want.latitude_degrees));
                check_field("longitude_degrees", m_tdata[45:35], want.longitude_degrees);
                check_field("year", 11'(m_tdata[53:46]), 11'(want.year));
                check_field("month", 11'(m_tdata[61:54]), 11'(want.month));
                check_field("day", 11'(m_tdata[69:62]), 11'(want.day));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** nmea_rmc_sentence_parser_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_valid_sentences();
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        put_text("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W");
        ship_frame(SUM_UPPER);
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        put_text("GPRMC,235959,V,9000.000,S,17959.999,W,0.0,359.9,311299,,,");
        ship_frame(SUM_LOWER);
        wait_idle();
    endtask

    task automatic test_status_codes();
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        put_text("GPGGA,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,");
        ship_frame(SUM_UPPER);
        put_text("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,");
        ship_frame(SUM_NONE);
        put_text("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,");
        ship_frame(SUM_WRONG);
        // empty status field
        put_text("GPRMC,123519,,4807.038,N,01131.000,E,022.4,084.4,230394,");
        ship_frame(SUM_UPPER);
        // too few fields
        put_text("GPRMC,123519,A,4807.038,N");
        ship_frame(SUM_UPPER);
        // wrong header outranks missing star
        put_text("GPRMX,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,");
        ship_frame(SUM_NONE);
        wait_idle();
    endtask

    task automatic test_odd_sentences();
        logic [7:0] s;
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        // hex letters and stray bytes in digit positions, 0xFF as fix status
        put_text("GPRMC,FFfa9Z,");
        frame_buf.push_back(8'hFF);
        put_text(",AB,N,F9F,E,x,y,ffFFff,");
        ship_frame(SUM_UPPER);
        // one-character fields: captures run on into later fields
        put_text("GPRMC,1,A,4,N,5,E,6,7,8,");
        ship_frame(SUM_LOWER);
        // star inside a field; the comma after it still ends a field
        put_text("GPRMC,1,2,3,4,5,6,7,*,8,");
        ship_frame(SUM_UPPER);
        // '$' and NUL inside the time field
        put_text("GPRMC,12$4");
        frame_buf.push_back(8'h00);
        put_text("6,A,4807.038,N,01131.000,E,022.4,084.4,230394,");
        ship_frame(SUM_UPPER);
        // check digits are the CR LF themselves
        put_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,*");
        frame_buf.push_back(CHR_CR);
        frame_buf.push_back(CHR_LF);
        ship_raw();
        // CR without LF and LF without CR before the real end
        put_text("GPRMC,081836,A,3751.65,S,14507.36,E,000.0,360.0,130998,");
        s = body_sum();
        frame_buf.push_front(CHR_DOLLAR);
        frame_buf.push_back(CHR_STAR);
        frame_buf.push_back(hex_char(s[7:4], 1'b0));
        frame_buf.push_back(hex_char(s[3:0], 1'b0));
        frame_buf.push_back(CHR_CR);
        frame_buf.push_back("q");
        frame_buf.push_back(CHR_LF);
        frame_buf.push_back(CHR_CR);
        frame_buf.push_back(CHR_CR);
        frame_buf.push_back(CHR_LF);
        ship_raw();
        // noise while hunting
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHR_STAR);
        send_byte(CHR_CR);
        send_byte(CHR_LF);
        send_byte(CHR_COMMA);
        wait_idle();
    endtask

    task automatic test_length_limits();
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        // exactly the longest sentence allowed
        put_text("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,");
        while (frame_buf.size() < FRAME_MAX - 6)
            frame_buf.push_back("0");
        ship_frame(SUM_UPPER);
        // one byte too long: the final LF overflows
        put_text("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,");
        while (frame_buf.size() < FRAME_MAX - 5)
            frame_buf.push_back("0");
        ship_frame(SUM_UPPER);
        // runaway sentence with no end
        send_byte(CHR_DOLLAR);
        repeat (FRAME_MAX + 40) send_byte("X");
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int         first_due;
        int         first_sent;
        int         roll;
        int         len;
        int         nfields;
        logic [7:0] c;
        sum_mode_t  mode;
        first_due  = reports_due;
        first_sent = bytes_sent;
        while (reports_due - first_due < 45 && bytes_sent - first_sent < 550) begin
            tx_gaps_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                repeat ($urandom_range(1, 24)) send_byte(8'($urandom_range(0, 255)));
            end
            else if (roll < 13) begin
                send_byte(CHR_DOLLAR);
                repeat ($urandom_range(FRAME_MAX - 8, FRAME_MAX + 16))
                    send_byte(8'($urandom_range(0, 255)));
            end
            else begin
                if ($urandom_range(0, 19) == 0)
                    put_text("GPGSV,");
                else
                    put_text("GPRMC,");
                if ($urandom_range(0, 24) == 0)
                    frame_buf[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
                nfields = ($urandom_range(0, 99) < 6) ? $urandom_range(5, 8)
                                                      : $urandom_range(9, 12);
                for (int f = 0; f < nfields; f++) begin
                    roll = $urandom_range(0, 99);
                    len = (f < NUM_FIELDS) ? FIELD_WIDTH[f] : $urandom_range(0, 5);
                    if (roll < 4)
                        len = 0;
                    else if (roll < 16)
                        len = $urandom_range(1, 3);
                    for (int i = 0; i < len; i++) begin
                        c = rand_field_char();
                        if (f == 1 && roll >= 16)
                            c = $urandom_range(0, 1) ? "A" : "V";
                        frame_buf.push_back(c);
                    end
                    frame_buf.push_back(CHR_COMMA);
                end
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    mode = SUM_UPPER;
                else if (roll < 85)
                    mode = SUM_LOWER;
                else if (roll < 95)
                    mode = SUM_WRONG;
                else
                    mode = SUM_NONE;
                ship_frame(mode);
            end
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        m_tready = 1'b0;
        clear_parser();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_valid_sentences();
        test_status_codes();
        test_odd_sentences();
        test_length_limits();
        test_random_traffic();

        if (error_count == 0)
            $display("** nmea_rmc_sentence_parser_unit: PASSED **");
        else
            $display("** nmea_rmc_sentence_parser_unit: FAILED **");
        $finish;
    end

endmodule
